[rtl/ffha_pkg.sv]
// Package for the first-fit heap allocator.
// Holds the shared codes, field widths and parameter defaults; no dependencies.
package ffha_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_ARENA_BYTES  = 65536;

    localparam int ADDR_W   = 32;
    localparam int REQ_W    = 17;
    localparam int HSIZE_W  = 17;
    localparam int USED_W   = 17;
    localparam int STATUS_W = 2;
    localparam int ALU_W    = 32;

    localparam int MIN_HEAP_BYTES = 64;
    localparam logic [HSIZE_W-1:0] RESET_HEAP_SIZE = HSIZE_W'(65536);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

[rtl/ffha_alu.sv]
// Shared three-operand adder/subtractor of the heap allocator.
// Depends on ffha_pkg for the operation codes and the datapath width.
module ffha_alu (
    input  ffha_pkg::t_alu_op          i_op,
    input  logic [ffha_pkg::ALU_W-1:0] i_a,
    input  logic [ffha_pkg::ALU_W-1:0] i_b,
    input  logic [ffha_pkg::ALU_W-1:0] i_c,
    output logic [ffha_pkg::ALU_W:0]   o_y
);
    import ffha_pkg::*;

    // The top bit is the carry of an add or the borrow of a subtract.
    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = {1'b0, i_a} + {1'b0, i_b} + {1'b0, i_c};
            ALU_SUB: o_y = {1'b0, i_a} - {1'b0, i_b} - {1'b0, i_c};
            default: o_y = '0;
        endcase
    end

endmodule

[rtl/ffha_table.sv]
// Block table memory of the heap allocator: one write port, one read port,
// registered read data that holds between reads. No dependencies.
module ffha_table #(
    parameter int DEPTH = 64,
    parameter int ENT_W = 46
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [ENT_W-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [ENT_W-1:0]         o_rdata
);
    logic [ENT_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator with coalescing. Each item is an allocate or a free
// and yields one result item. The block table lives in a single-port-read memory
// and one shared adder does the size, offset and address sums, so the walk along
// the address-ordered chain costs one cycle per block visited. An allocate walks
// the chain, then on a fit with room to spare scans for a spare table entry and
// splits the block; a free walks the chain and then merges with free neighbours.
// No new item is taken until the result has moved into the output register, which
// waits while the output is stalled. After reset, and after any write to heap_base
// or heap_size, the arena is rebuilt as one free block in states S_INIT and S_INIT2
// before the next item is taken.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int ARENA_BYTES  = ffha_pkg::DEF_ARENA_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic [ffha_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_body_address,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ffha_pkg::STATUS_W-1:0]    o_status,
    output logic [ffha_pkg::ADDR_W-1:0]      o_granted_address,
    output logic [ffha_pkg::USED_W-1:0]      o_used_bytes,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]      i_cfg_data
);
    import ffha_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LNK_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W   = $clog2(ARENA_BYTES + 1);
    localparam int HS_W   = (SZ_W > HSIZE_W) ? SZ_W : HSIZE_W;
    localparam int WANT_W = REQ_W + 1;
    localparam int ENT_W  = 2 * SZ_W + 2 * LNK_W;
    localparam int CMP_W  = SZ_W + USED_W;

    localparam logic [LNK_W-1:0] LINK_NONE = LNK_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [ALU_W-1:0] HDR       = ALU_W'(HEADER_BYTES);
    localparam logic [ALU_W-1:0] TWO_HDR   = ALU_W'(2 * HEADER_BYTES);

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_INIT2  = 5'd1;
    localparam logic [4:0] S_IDLE   = 5'd2;
    localparam logic [4:0] S_PREP   = 5'd3;
    localparam logic [4:0] S_WALK   = 5'd4;
    localparam logic [4:0] S_SCAN   = 5'd5;
    localparam logic [4:0] S_SPLIT0 = 5'd6;
    localparam logic [4:0] S_SPLIT1 = 5'd7;
    localparam logic [4:0] S_SPLIT2 = 5'd8;
    localparam logic [4:0] S_SPLIT3 = 5'd9;
    localparam logic [4:0] S_A_USED = 5'd10;
    localparam logic [4:0] S_A_ADDR = 5'd11;
    localparam logic [4:0] S_F_DEC  = 5'd12;
    localparam logic [4:0] S_M_N1   = 5'd13;
    localparam logic [4:0] S_M_N2   = 5'd14;
    localparam logic [4:0] S_M_P    = 5'd15;
    localparam logic [4:0] S_M_P1   = 5'd16;
    localparam logic [4:0] S_M_P2   = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    logic [4:0]            r_state, n_state;
    logic [ADDR_W-1:0]     r_heap_base, n_heap_base;
    logic [HSIZE_W-1:0]    r_heap_size, n_heap_size;
    logic [ADDR_W-1:0]     r_base_h, n_base_h;
    logic [SZ_W-1:0]       r_hs, n_hs;
    logic [MAX_BLOCKS-1:0] r_in_use, n_in_use;
    logic [MAX_BLOCKS-1:0] r_free, n_free;
    logic [USED_W-1:0]     r_used, n_used;
    logic                  r_kind, n_kind;
    logic [WANT_W-1:0]     r_want, n_want;
    logic [ADDR_W-1:0]     r_key, n_key;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [IDX_W-1:0]      r_steps, n_steps;
    logic [IDX_W-1:0]      r_scan, n_scan;
    logic [IDX_W-1:0]      r_spare, n_spare;
    logic [SZ_W-1:0]       r_tmp_off, n_tmp_off;
    logic [SZ_W-1:0]       r_cur_off, n_cur_off;
    logic [SZ_W-1:0]       r_cur_size, n_cur_size;
    logic [LNK_W-1:0]      r_cur_next, n_cur_next;
    logic [LNK_W-1:0]      r_cur_prev, n_cur_prev;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [ADDR_W-1:0]     r_res_granted, n_res_granted;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [ADDR_W-1:0]     r_out_granted, n_out_granted;
    logic [USED_W-1:0]     r_out_used, n_out_used;

    t_alu_op           alu_op;
    logic [ALU_W-1:0]  alu_a, alu_b, alu_c;
    logic [ALU_W:0]    alu_y;

    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [ENT_W-1:0]  mem_wdata, mem_rdata;

    logic [SZ_W-1:0]   rd_off, rd_size;
    logic [LNK_W-1:0]  rd_next, rd_prev;
    logic [HS_W-1:0]   hs_raw, hs_clamp;
    logic              in_acc, cfg_acc;
    logic              cur_next_ok, cur_prev_ok, rd_next_ok;
    logic [IDX_W-1:0]  cur_next_idx, cur_prev_idx, rd_next_idx;

    assign rd_off  = mem_rdata[ENT_W-1 -: SZ_W];
    assign rd_size = mem_rdata[2*LNK_W+SZ_W-1 -: SZ_W];
    assign rd_next = mem_rdata[2*LNK_W-1 -: LNK_W];
    assign rd_prev = mem_rdata[LNK_W-1:0];

    assign cur_next_ok  = r_cur_next < LINK_NONE;
    assign cur_prev_ok  = r_cur_prev < LINK_NONE;
    assign rd_next_ok   = rd_next < LINK_NONE;
    assign cur_next_idx = r_cur_next[IDX_W-1:0];
    assign cur_prev_idx = r_cur_prev[IDX_W-1:0];
    assign rd_next_idx  = rd_next[IDX_W-1:0];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_INIT) || (r_state == S_INIT2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // The value of the arena size register is clamped to the supported range before use.
    always_comb begin
        hs_raw = HS_W'(r_heap_size);
        if (hs_raw > HS_W'(ARENA_BYTES)) begin
            hs_clamp = HS_W'(ARENA_BYTES);
        end else if (hs_raw < HS_W'(MIN_HEAP_BYTES)) begin
            hs_clamp = HS_W'(MIN_HEAP_BYTES);
        end else begin
            hs_clamp = hs_raw;
        end
    end

    ffha_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_c  (alu_c),
        .o_y  (alu_y)
    );

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .ENT_W (ENT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_heap_base   = r_heap_base;
        n_heap_size   = r_heap_size;
        n_base_h      = r_base_h;
        n_hs          = r_hs;
        n_in_use      = r_in_use;
        n_free        = r_free;
        n_used        = r_used;
        n_kind        = r_kind;
        n_want        = r_want;
        n_key         = r_key;
        n_cur         = r_cur;
        n_steps       = r_steps;
        n_scan        = r_scan;
        n_spare       = r_spare;
        n_tmp_off     = r_tmp_off;
        n_cur_off     = r_cur_off;
        n_cur_size    = r_cur_size;
        n_cur_next    = r_cur_next;
        n_cur_prev    = r_cur_prev;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_granted = r_out_granted;
        n_out_used    = r_out_used;

        alu_op    = ALU_ADD;
        alu_a     = '0;
        alu_b     = '0;
        alu_c     = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {SZ_W'(0), SZ_W'(hs_clamp - HS_W'(HEADER_BYTES)),
                             LINK_NONE, LINK_NONE};
                n_in_use    = MAX_BLOCKS'(1);
                n_free      = MAX_BLOCKS'(1);
                n_used      = '0;
                n_hs        = SZ_W'(hs_clamp);
                alu_op      = ALU_ADD;
                alu_a       = r_heap_base;
                alu_b       = ALU_W'(3);
                n_base_h    = alu_y[ADDR_W-1:0] & ~ADDR_W'(3);
                n_state     = S_INIT2;
            end
            S_INIT2: begin
                alu_op   = ALU_ADD;
                alu_a    = r_base_h;
                alu_b    = HDR;
                n_base_h = alu_y[ADDR_W-1:0];
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_kind  = i_kind;
                    n_want  = WANT_W'(i_request_bytes);
                    n_key   = i_body_address;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // Round the request up, or turn the address into an offset.
                if (r_kind == KIND_ALLOC) begin
                    alu_op = ALU_ADD;
                    alu_a  = ALU_W'(r_want);
                    alu_b  = ALU_W'(3);
                    n_want = alu_y[WANT_W-1:0] & ~WANT_W'(3);
                end else begin
                    alu_op = ALU_SUB;
                    alu_a  = r_key;
                    alu_b  = r_base_h;
                    n_key  = alu_y[ADDR_W-1:0];
                end
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_cur     = '0;
                n_steps   = '0;
                n_state   = S_WALK;
            end
            S_WALK: begin
                alu_op = ALU_SUB;
                if (r_kind == KIND_ALLOC) begin
                    alu_a = ALU_W'(rd_size);
                    alu_b = ALU_W'(r_want);
                end else begin
                    alu_a = r_key;
                    alu_b = ALU_W'(rd_off);
                end
                n_cur_off  = rd_off;
                n_cur_size = rd_size;
                n_cur_next = rd_next;
                n_cur_prev = rd_prev;
                if (r_kind == KIND_ALLOC && r_in_use[r_cur] && r_free[r_cur]
                        && !alu_y[ALU_W]) begin
                    n_res_status = ST_OK;
                    if (alu_y[ALU_W-1:0] > TWO_HDR) begin
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_free[r_cur] = 1'b0;
                        n_state       = S_A_USED;
                    end
                end else if (r_kind == KIND_FREE && r_in_use[r_cur] && !r_free[r_cur]
                        && alu_y[ALU_W-1:0] == '0) begin
                    n_res_status  = ST_OK;
                    n_res_granted = '0;
                    n_free[r_cur] = 1'b1;
                    mem_re        = rd_next_ok;
                    mem_raddr     = rd_next_idx;
                    n_state       = S_F_DEC;
                end else if (rd_next_ok && r_steps != IDX_LAST) begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_next_idx;
                    n_cur     = rd_next_idx;
                    n_steps   = r_steps + IDX_W'(1);
                end else begin
                    n_res_status  = (r_kind == KIND_ALLOC) ? ST_NOFIT : ST_BADADDR;
                    n_res_granted = '0;
                    n_state       = S_DONE;
                end
            end
            S_SCAN: begin
                // Lowest table entry not in use takes the split-off remainder.
                if (!r_in_use[r_scan]) begin
                    n_spare = r_scan;
                    n_state = S_SPLIT0;
                end else if (r_scan == IDX_LAST) begin
                    n_free[r_cur] = 1'b0;
                    n_state       = S_A_USED;
                end else begin
                    n_scan = r_scan + IDX_W'(1);
                end
            end
            S_SPLIT0: begin
                alu_op    = ALU_ADD;
                alu_a     = ALU_W'(r_cur_off);
                alu_b     = HDR;
                alu_c     = ALU_W'(r_want);
                n_tmp_off = alu_y[SZ_W-1:0];
                n_state   = S_SPLIT1;
            end
            S_SPLIT1: begin
                alu_op    = ALU_SUB;
                alu_a     = ALU_W'(r_cur_size);
                alu_b     = ALU_W'(r_want);
                alu_c     = HDR;
                mem_we    = 1'b1;
                mem_waddr = r_spare;
                mem_wdata = {r_tmp_off, alu_y[SZ_W-1:0], r_cur_next, LNK_W'(r_cur)};
                n_in_use[r_spare] = 1'b1;
                n_free[r_spare]   = 1'b1;
                mem_re    = cur_next_ok;
                mem_raddr = cur_next_idx;
                n_state   = cur_next_ok ? S_SPLIT2 : S_SPLIT3;
            end
            S_SPLIT2: begin
                mem_we    = 1'b1;
                mem_waddr = cur_next_idx;
                mem_wdata = {rd_off, rd_size, rd_next, LNK_W'(r_spare)};
                n_state   = S_SPLIT3;
            end
            S_SPLIT3: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {r_cur_off, SZ_W'(r_want), LNK_W'(r_spare), r_cur_prev};
                n_cur_size    = SZ_W'(r_want);
                n_free[r_cur] = 1'b0;
                n_state       = S_A_USED;
            end
            S_A_USED: begin
                alu_op  = ALU_ADD;
                alu_a   = ALU_W'(r_used);
                alu_b   = ALU_W'(r_cur_size);
                alu_c   = HDR;
                n_used  = alu_y[USED_W-1:0];
                n_state = S_A_ADDR;
            end
            S_A_ADDR: begin
                alu_op        = ALU_ADD;
                alu_a         = r_base_h;
                alu_b         = ALU_W'(r_cur_off);
                n_res_granted = alu_y[ADDR_W-1:0];
                n_state       = S_DONE;
            end
            S_F_DEC: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(r_used);
                alu_b  = ALU_W'(r_cur_size);
                alu_c  = HDR;
                n_used = alu_y[ALU_W] ? '0 : alu_y[USED_W-1:0];
                if (cur_next_ok && r_in_use[cur_next_idx] && r_free[cur_next_idx]) begin
                    n_state = S_M_N1;
                end else begin
                    n_state = S_M_P;
                end
            end
            S_M_N1: begin
                // Absorb the free next neighbour, whose entry is in the read data.
                alu_op    = ALU_ADD;
                alu_a     = ALU_W'(r_cur_size);
                alu_b     = ALU_W'(rd_size);
                alu_c     = HDR;
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {r_cur_off, alu_y[SZ_W-1:0], rd_next, r_cur_prev};
                n_cur_size = alu_y[SZ_W-1:0];
                n_cur_next = rd_next;
                n_in_use[cur_next_idx] = 1'b0;
                n_free[cur_next_idx]   = 1'b0;
                mem_re    = rd_next_ok;
                mem_raddr = rd_next_idx;
                n_state   = rd_next_ok ? S_M_N2 : S_M_P;
            end
            S_M_N2: begin
                mem_we    = 1'b1;
                mem_waddr = cur_next_idx;
                mem_wdata = {rd_off, rd_size, rd_next, LNK_W'(r_cur)};
                n_state   = S_M_P;
            end
            S_M_P: begin
                if (cur_prev_ok && r_in_use[cur_prev_idx] && r_free[cur_prev_idx]) begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_prev_idx;
                    n_state   = S_M_P1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_P1: begin
                alu_op    = ALU_ADD;
                alu_a     = ALU_W'(rd_size);
                alu_b     = ALU_W'(r_cur_size);
                alu_c     = HDR;
                mem_we    = 1'b1;
                mem_waddr = cur_prev_idx;
                mem_wdata = {rd_off, alu_y[SZ_W-1:0], r_cur_next, rd_prev};
                n_in_use[r_cur] = 1'b0;
                n_free[r_cur]   = 1'b0;
                mem_re    = cur_next_ok;
                mem_raddr = cur_next_idx;
                n_state   = cur_next_ok ? S_M_P2 : S_DONE;
            end
            S_M_P2: begin
                mem_we    = 1'b1;
                mem_waddr = cur_next_idx;
                mem_wdata = {rd_off, rd_size, rd_next, r_cur_prev};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_out_used    = r_used;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // Either register write rebuilds the arena.
        if (cfg_acc) begin
            case (i_cfg_index)
                CFG_HEAP_BASE: begin
                    n_heap_base = i_cfg_data;
                    n_state     = S_INIT;
                end
                CFG_HEAP_SIZE: begin
                    n_heap_size = i_cfg_data[HSIZE_W-1:0];
                    n_state     = S_INIT;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_heap_base <= '0;
            r_heap_size <= RESET_HEAP_SIZE;
            r_hs        <= '0;
            r_in_use    <= '0;
            r_free      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_heap_base <= n_heap_base;
            r_heap_size <= n_heap_size;
            r_hs        <= n_hs;
            r_in_use    <= n_in_use;
            r_free      <= n_free;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_h      <= n_base_h;
        r_kind        <= n_kind;
        r_want        <= n_want;
        r_key         <= n_key;
        r_cur         <= n_cur;
        r_steps       <= n_steps;
        r_scan        <= n_scan;
        r_spare       <= n_spare;
        r_tmp_off     <= n_tmp_off;
        r_cur_off     <= n_cur_off;
        r_cur_size    <= n_cur_size;
        r_cur_next    <= n_cur_next;
        r_cur_prev    <= n_cur_prev;
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status  <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_used    <= n_out_used;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_granted;
    assign o_used_bytes      = r_out_used;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc) |=> (r_state == S_PREP))
        else $error("block not busy after taking an item");

    a_free_implies_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free & ~r_in_use) == '0)
        else $error("free block without a table entry");

    a_first_block_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> r_in_use[0])
        else $error("first block lost from the table");

    a_used_within_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_used) <= CMP_W'(r_hs))
        else $error("used bytes exceed the arena");

    a_no_address_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_address == '0))
        else $error("address given with an error status");

endmodule
